// ===== hw/rtl/tlrq_pkg.sv =====
package tlrq_pkg;

  localparam int NUM_LEVELS      = 3;
  localparam int LVL_W           = 2;
  localparam int DEF_LEVEL_DEPTH = 16;

  localparam logic [31:0] POISON_IDENT = 32'hFFFF_FFFF;
  localparam logic [31:0] MAX_PRIO     = 32'd2;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PRIO = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic               command;
    logic signed [31:0] task_priority;
    logic signed [31:0] task_ident;
    logic signed [31:0] exec_duration;
    logic        [63:0] arrival_stamp;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic        [1:0]  level_used;
    logic signed [31:0] out_priority;
    logic signed [31:0] out_ident;
    logic signed [31:0] out_duration;
    logic        [63:0] out_arrival;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prio;
    logic [31:0] ident;
    logic [31:0] duration;
    logic [63:0] arrival;
    logic [63:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

endpackage

// ===== hw/rtl/tlrq_ram.sv =====
module tlrq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/tlrq_ctrl.sv =====
module tlrq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlrq_pkg::ctrl_cmd_t  cmd
);

  import tlrq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.capture   = (state_r == S_IDLE) && in_valid;
    cmd.commit    = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r && state_r == S_IDLE)
    else $error("committed transaction not presented");

  a_exec_drains: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC && !out_valid_r |=> state_r == S_IDLE)
    else $error("execute stalled with free output");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !cmd.commit)
    else $error("pending result overwritten");

endmodule

// ===== hw/rtl/tlrq_dp.sv =====
module tlrq_dp #(
  parameter int LEVEL_DEPTH = tlrq_pkg::DEF_LEVEL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  tlrq_pkg::ctrl_cmd_t  cmd,
  input  tlrq_pkg::in_item_t   in_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  output tlrq_pkg::out_item_t  out_data
);

  import tlrq_pkg::*;

  localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
  localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    adv = (p == PTR_W'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  in_item_t         req_r;
  out_item_t        out_r;
  out_item_t        res;
  logic             mode_r;
  logic [63:0]      stamp_r;
  logic [PTR_W-1:0] rd_ptr_r [NUM_LEVELS];
  logic [PTR_W-1:0] wr_ptr_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r    [NUM_LEVELS];
  entry_t           head     [NUM_LEVELS];
  entry_t           new_entry;

  logic             is_enq;
  logic             poison;
  logic             bad_prio;
  logic             lvl_full;
  logic [LVL_W-1:0] enq_lvl;
  logic             enq_ok;
  logic             found;
  logic [LVL_W-1:0] pick;
  logic [63:0]      best;
  logic             deq_ok;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    is_enq   = (req_r.command == CMD_ENQ);
    poison   = (req_r.task_ident == POISON_IDENT);
    bad_prio = !poison && ($unsigned(req_r.task_priority) > MAX_PRIO);
    enq_lvl  = poison ? '0 : req_r.task_priority[LVL_W-1:0];
    lvl_full = (cnt_r[enq_lvl] == CNT_W'(LEVEL_DEPTH));
    enq_ok   = is_enq && !bad_prio && !lvl_full;

    new_entry.prio     = req_r.task_priority;
    new_entry.ident    = req_r.task_ident;
    new_entry.duration = req_r.exec_duration;
    new_entry.arrival  = req_r.arrival_stamp;
    new_entry.stamp    = stamp_r;

    found = 1'b0;
    pick  = '0;
    best  = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (cnt_r[i] != '0) begin
        if (!found || (!mode_r && head[i].stamp < best)) begin
          found = 1'b1;
          pick  = LVL_W'(i);
          best  = head[i].stamp;
        end
      end
    end
    deq_ok = !is_enq && found;

    res = '0;
    if (is_enq) begin
      if (bad_prio) begin
        res.status = ST_BAD_PRIO;
      end else if (lvl_full) begin
        res.status = ST_FULL;
      end else begin
        res.status     = ST_OK;
        res.level_used = enq_lvl;
      end
    end else if (!found) begin
      res.status = ST_EMPTY;
    end else begin
      res.status       = ST_OK;
      res.level_used   = pick;
      res.out_priority = head[pick].prio;
      res.out_ident    = head[pick].ident;
      res.out_duration = head[pick].duration;
      res.out_arrival  = head[pick].arrival;
    end
  end

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    tlrq_ram #(
      .DEPTH (LEVEL_DEPTH),
      .WIDTH (ENTRY_W),
      .AW    (PTR_W)
    ) u_ram (
      .clk     (clk),
      .wr_en   (cmd.commit && enq_ok && enq_lvl == LVL_W'(g)),
      .wr_addr (wr_ptr_r[g]),
      .wr_data (new_entry),
      .rd_addr (rd_ptr_r[g]),
      .rd_data (head[g])
    );
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      stamp_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        rd_ptr_r[i] <= '0;
        wr_ptr_r[i] <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
      if (cmd.commit && enq_ok) begin
        stamp_r <= stamp_r + 64'd1;
      end
      for (int i = 0; i < NUM_LEVELS; i++) begin
        if (cmd.commit && enq_ok && enq_lvl == LVL_W'(i)) begin
          wr_ptr_r[i] <= adv(wr_ptr_r[i]);
          cnt_r[i]    <= cnt_r[i] + 1'b1;
        end
        if (cmd.commit && deq_ok && pick == LVL_W'(i)) begin
          rd_ptr_r[i] <= adv(rd_ptr_r[i]);
          cnt_r[i]    <= cnt_r[i] - 1'b1;
        end
      end
    end
  end

  assign out_data = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] <= CNT_W'(LEVEL_DEPTH) && cnt_r[1] <= CNT_W'(LEVEL_DEPTH) &&
    cnt_r[2] <= CNT_W'(LEVEL_DEPTH))
    else $error("level count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] != '0 || rd_ptr_r[0] == wr_ptr_r[0]) &&
    (cnt_r[1] != '0 || rd_ptr_r[1] == wr_ptr_r[1]) &&
    (cnt_r[2] != '0 || rd_ptr_r[2] == wr_ptr_r[2]))
    else $error("empty level with split pointers");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && !enq_ok |=> stamp_r == $past(stamp_r))
    else $error("stamp consumed without store");

endmodule

// ===== hw/rtl/three_level_ready_queue.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_data   (tlrq_pkg::in_item_t)
// out_     output     out_valid/out_stall out_data  (tlrq_pkg::out_item_t)
// cfg_     input      cfg_wr_en           cfg_wr_data (dequeue mode, bit 0)
//
// A transaction goes through accept and head read, then select and commit.
// The three per-level entry memories are read at their head pointers every cycle.
// Reset is synchronous; it empties all levels and clears the stamp and mode.
// A result waiting under out_stall holds the select and commit step of the next transaction.
module three_level_ready_queue #(
  parameter int LEVEL_DEPTH = tlrq_pkg::DEF_LEVEL_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlrq_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlrq_pkg::out_item_t  out_data,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data
);

  import tlrq_pkg::*;

  ctrl_cmd_t cmd;

  tlrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  tlrq_dp #(
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule
